[rtl/cmq_pkg.sv]
// ----------------------------------------------------------------------------
// cmq_pkg
// shared types, codes and constants for the gated can message queues
// ----------------------------------------------------------------------------
package cmq_pkg;

  localparam int NumQueues  = 6;
  localparam int MaxDepth   = 64;
  localparam int PtrW       = $clog2(MaxDepth);
  localparam int DepthW     = PtrW + 1;
  localparam int QueueW     = 3;
  localparam int AddrW      = QueueW + PtrW;
  localparam int MemDepth   = NumQueues * MaxDepth;
  localparam int KindW      = 2;
  localparam int IdW        = 29;
  localparam int LenW       = 4;
  localparam int PayW       = 64;
  localparam int HdrW       = KindW + IdW + LenW;
  localparam int EntryW     = HdrW + PayW;
  localparam int InDataW    = 112;
  localparam int InUserW    = 6;
  localparam int OutDataW   = 104;
  localparam int OutUserW   = 1;

  localparam int DefaultDepth = 8;

  localparam logic [7:0]      EnableReset = 8'hFF;
  localparam logic [LenW-1:0] MaxLen      = 4'd8;

  typedef enum logic [2:0] {
    CmdWrite = 3'd0,
    CmdRead  = 3'd1,
    CmdNm    = 3'd2,
    CmdDiag  = 3'd3,
    CmdClear = 3'd4
  } cmd_e;

  localparam logic [QueueW-1:0] ChAppRx  = 3'd0;
  localparam logic [QueueW-1:0] ChAppTx  = 3'd1;
  localparam logic [QueueW-1:0] ChNmRx   = 3'd2;
  localparam logic [QueueW-1:0] ChNmTx   = 3'd3;
  localparam logic [QueueW-1:0] ChDiagRx = 3'd4;
  localparam logic [QueueW-1:0] ChDiagTx = 3'd5;

  localparam logic [1:0] CtrlBothOn  = 2'd0;
  localparam logic [1:0] CtrlRxOnly  = 2'd1;
  localparam logic [1:0] CtrlTxOnly  = 2'd2;
  localparam logic [1:0] CtrlBothOff = 2'd3;
  localparam logic [1:0] ComApp      = 2'd0;
  localparam logic [1:0] ComNm       = 2'd1;
  localparam logic [1:0] ComBoth     = 2'd2;
  localparam logic [1:0] ComNone     = 2'd3;

  localparam logic [7:0] WriteNeed [NumQueues] = '{8'h11, 8'h22, 8'h40, 8'h80, 8'h04, 8'h08};

  typedef struct packed {
    logic              we;
    logic              re;
    logic [AddrW-1:0]  addr;
    logic [EntryW-1:0] wdata;
  } mem_req_t;

  function automatic logic [DepthW-1:0] clamp_depth(input int d);
    logic [DepthW-1:0] r;
    if (d < 1) begin
      r = DepthW'(1);
    end else if (d > MaxDepth) begin
      r = DepthW'(MaxDepth);
    end else begin
      r = DepthW'(d);
    end
    return r;
  endfunction

endpackage

[rtl/cmq_store.sv]
// ----------------------------------------------------------------------------
// cmq_store
// message entry memory, one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module cmq_store (
  input  logic                     clk_i,
  input  cmq_pkg::mem_req_t        req_i,
  output logic [cmq_pkg::EntryW-1:0] rdata_o
);

  logic [cmq_pkg::EntryW-1:0] mem [0:cmq_pkg::MemDepth-1];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem[req_i.addr];
    end
  end

endmodule

[rtl/cmq_ctrl.sv]
// ----------------------------------------------------------------------------
// cmq_ctrl
// command decode, queue pointers, enable gating and result register
// ----------------------------------------------------------------------------
module cmq_ctrl #(
  parameter int APP_RX_DEPTH  = cmq_pkg::DefaultDepth,
  parameter int APP_TX_DEPTH  = cmq_pkg::DefaultDepth,
  parameter int NM_RX_DEPTH   = cmq_pkg::DefaultDepth,
  parameter int NM_TX_DEPTH   = cmq_pkg::DefaultDepth,
  parameter int DIAG_RX_DEPTH = cmq_pkg::DefaultDepth,
  parameter int DIAG_TX_DEPTH = cmq_pkg::DefaultDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [cmq_pkg::InDataW-1:0]  in_data_i,
  input  logic [cmq_pkg::InUserW-1:0]  in_user_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cmq_pkg::OutDataW-1:0] out_data_o,
  output logic [cmq_pkg::OutUserW-1:0] out_user_o,
  output cmq_pkg::mem_req_t            mem_req_o,
  input  logic [cmq_pkg::EntryW-1:0]   mem_rdata_i
);

  typedef enum logic {
    StIdle,
    StRead
  } state_e;

  localparam logic [cmq_pkg::DepthW-1:0] QDepth [cmq_pkg::NumQueues] = '{
    cmq_pkg::clamp_depth(APP_RX_DEPTH), cmq_pkg::clamp_depth(APP_TX_DEPTH),
    cmq_pkg::clamp_depth(NM_RX_DEPTH),  cmq_pkg::clamp_depth(NM_TX_DEPTH),
    cmq_pkg::clamp_depth(DIAG_RX_DEPTH), cmq_pkg::clamp_depth(DIAG_TX_DEPTH)
  };

  state_e                        state_q, state_d;
  logic [cmq_pkg::PtrW-1:0]      wr_ptr_q [cmq_pkg::NumQueues];
  logic [cmq_pkg::PtrW-1:0]      wr_ptr_d [cmq_pkg::NumQueues];
  logic [cmq_pkg::PtrW-1:0]      rd_ptr_q [cmq_pkg::NumQueues];
  logic [cmq_pkg::PtrW-1:0]      rd_ptr_d [cmq_pkg::NumQueues];
  logic [cmq_pkg::NumQueues-1:0] full_q, full_d;
  logic [7:0]                    en_q, en_d;
  logic                          out_valid_q, out_valid_d;
  logic                          ok_q, ok_d;
  logic [cmq_pkg::HdrW-1:0]      hdr_q, hdr_d;
  logic [cmq_pkg::PayW-1:0]      pay_q, pay_d;

  // input fields
  cmq_pkg::cmd_e                 cmd;
  logic [cmq_pkg::QueueW-1:0]    channel;
  logic [cmq_pkg::KindW-1:0]     frame_kind;
  logic [cmq_pkg::IdW-1:0]       msg_id;
  logic [cmq_pkg::PayW-1:0]      payload;
  logic [cmq_pkg::LenW-1:0]      length;
  logic                          rx_side, enable_flag, no_ack, bus_off;
  logic [1:0]                    ctrl_type, com_type;

  assign cmd         = cmq_pkg::cmd_e'(in_user_i[2:0]);
  assign channel     = in_user_i[5:3];
  assign frame_kind  = in_data_i[1:0];
  assign msg_id      = in_data_i[30:2];
  assign payload     = in_data_i[94:31];
  assign length      = in_data_i[98:95];
  assign rx_side     = in_data_i[99];
  assign enable_flag = in_data_i[100];
  assign ctrl_type   = in_data_i[102:101];
  assign com_type    = in_data_i[104:103];
  assign no_ack      = in_data_i[105];
  assign bus_off     = in_data_i[106];

  logic                          fire;
  logic                          q_valid;
  logic [cmq_pkg::QueueW-1:0]    qi;
  logic [cmq_pkg::LenW-1:0]      len_sat;
  logic [cmq_pkg::PayW-1:0]      pay_masked;
  logic [cmq_pkg::PtrW-1:0]      w_next, r_next;
  logic                          link_gated, gate_ok, is_empty;
  logic                          rx_on, tx_on;
  logic [7:0]                    nm_bits, sel, set;

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign fire       = in_valid_i && in_ready_o;
  assign q_valid    = channel < cmq_pkg::QueueW'(cmq_pkg::NumQueues);
  assign qi         = q_valid ? channel : cmq_pkg::ChAppRx;
  assign len_sat    = (length > cmq_pkg::MaxLen) ? cmq_pkg::MaxLen : length;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pay_masked[8*i +: 8] = (cmq_pkg::LenW'(i) < len_sat) ? payload[8*i +: 8] : 8'h00;
    end
  end

  assign w_next = ({1'b0, wr_ptr_q[qi]} + cmq_pkg::DepthW'(1) >= QDepth[qi]) ?
                  '0 : wr_ptr_q[qi] + cmq_pkg::PtrW'(1);
  assign r_next = ({1'b0, rd_ptr_q[qi]} + cmq_pkg::DepthW'(1) >= QDepth[qi]) ?
                  '0 : rd_ptr_q[qi] + cmq_pkg::PtrW'(1);

  assign link_gated = (qi == cmq_pkg::ChAppRx) || (qi == cmq_pkg::ChAppTx) ||
                      (qi == cmq_pkg::ChDiagRx) || (qi == cmq_pkg::ChDiagTx);
  assign gate_ok    = ((en_q & cmq_pkg::WriteNeed[qi]) == cmq_pkg::WriteNeed[qi]) &&
                      !full_q[qi] && !(link_gated && (no_ack || bus_off));
  assign is_empty   = (rd_ptr_q[qi] == wr_ptr_q[qi]) && !full_q[qi];

  assign rx_on   = (ctrl_type == cmq_pkg::CtrlBothOn) || (ctrl_type == cmq_pkg::CtrlRxOnly);
  assign tx_on   = (ctrl_type == cmq_pkg::CtrlBothOn) || (ctrl_type == cmq_pkg::CtrlTxOnly);
  assign nm_bits = rx_side ? 8'h05 : 8'h0A;

  always_comb begin
    sel = 8'h00;
    set = 8'h00;
    if ((com_type == cmq_pkg::ComApp) || (com_type == cmq_pkg::ComBoth)) begin
      sel = sel | 8'h30;
      set = set | {2'b00, tx_on, rx_on, 4'h0};
    end
    if ((com_type == cmq_pkg::ComNm) || (com_type == cmq_pkg::ComBoth)) begin
      sel = sel | 8'hC0;
      set = set | {tx_on, rx_on, 6'h00};
    end
  end

  always_comb begin
    state_d     = state_q;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    full_d      = full_q;
    en_d        = en_q;
    ok_d        = ok_q;
    hdr_d       = hdr_q;
    pay_d       = pay_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_req_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (fire) begin
          out_valid_d = 1'b1;
          ok_d        = 1'b0;
          hdr_d       = '0;
          pay_d       = '0;
          unique case (cmd)
            cmq_pkg::CmdWrite: begin
              if (q_valid && gate_ok) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.addr  = {qi, wr_ptr_q[qi]};
                mem_req_o.wdata = {frame_kind, msg_id, len_sat, pay_masked};
                wr_ptr_d[qi]    = w_next;
                if (w_next == rd_ptr_q[qi]) begin
                  full_d[qi] = 1'b1;
                end
                ok_d = 1'b1;
              end
            end
            cmq_pkg::CmdRead: begin
              if (q_valid && !is_empty) begin
                mem_req_o.re   = 1'b1;
                mem_req_o.addr = {qi, rd_ptr_q[qi]};
                rd_ptr_d[qi]   = r_next;
                full_d[qi]     = 1'b0;
                out_valid_d    = 1'b0;
                state_d        = StRead;
              end
            end
            cmq_pkg::CmdNm: begin
              en_d = enable_flag ? (en_q | nm_bits) : (en_q & ~nm_bits);
              if (rx_side) begin
                wr_ptr_d[cmq_pkg::ChAppRx]  = '0;
                rd_ptr_d[cmq_pkg::ChAppRx]  = '0;
                full_d[cmq_pkg::ChAppRx]    = 1'b0;
                wr_ptr_d[cmq_pkg::ChDiagRx] = '0;
                rd_ptr_d[cmq_pkg::ChDiagRx] = '0;
                full_d[cmq_pkg::ChDiagRx]   = 1'b0;
              end else begin
                wr_ptr_d[cmq_pkg::ChAppTx]  = '0;
                rd_ptr_d[cmq_pkg::ChAppTx]  = '0;
                full_d[cmq_pkg::ChAppTx]    = 1'b0;
                wr_ptr_d[cmq_pkg::ChDiagTx] = '0;
                rd_ptr_d[cmq_pkg::ChDiagTx] = '0;
                full_d[cmq_pkg::ChDiagTx]   = 1'b0;
              end
              ok_d = 1'b1;
            end
            cmq_pkg::CmdDiag: begin
              en_d = (en_q & ~sel) | set;
              ok_d = 1'b1;
            end
            cmq_pkg::CmdClear: begin
              for (int i = 0; i < cmq_pkg::NumQueues; i++) begin
                wr_ptr_d[i] = '0;
                rd_ptr_d[i] = '0;
              end
              full_d = '0;
              ok_d   = 1'b1;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      StRead: begin
        out_valid_d = 1'b1;
        ok_d        = 1'b1;
        hdr_d       = mem_rdata_i[cmq_pkg::EntryW-1:cmq_pkg::PayW];
        pay_d       = mem_rdata_i[cmq_pkg::PayW-1:0];
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      for (int i = 0; i < cmq_pkg::NumQueues; i++) begin
        wr_ptr_q[i] <= '0;
        rd_ptr_q[i] <= '0;
      end
      full_q      <= '0;
      en_q        <= cmq_pkg::EnableReset;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      hdr_q       <= '0;
      pay_q       <= '0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      full_q      <= full_d;
      en_q        <= en_d;
      out_valid_q <= out_valid_d;
      ok_q        <= ok_d;
      hdr_q       <= hdr_d;
      pay_q       <= pay_d;
    end
  end

  // hdr_q: {kind, id, len}
  assign out_valid_o = out_valid_q;
  assign out_user_o  = ok_q;
  assign out_data_o  = {5'b0, pay_q, hdr_q[cmq_pkg::LenW-1:0],
                        hdr_q[cmq_pkg::HdrW-cmq_pkg::KindW-1:cmq_pkg::LenW],
                        hdr_q[cmq_pkg::HdrW-1:cmq_pkg::HdrW-cmq_pkg::KindW]};

endmodule

[rtl/gated_can_message_queues_unit.sv]
// ----------------------------------------------------------------------------
// gated_can_message_queues_unit
// six gated can message ring queues sharing one entry memory
// ----------------------------------------------------------------------------
// write, control and clear words: result registered next cycle
// read of a non-empty queue: memory read registered in StRead, then the result register; no new word taken meanwhile
// any other word: one word per cycle when the result side keeps up
// reset: pointers and full flags cleared, enables all ones, memory not cleared
// ----------------------------------------------------------------------------
module gated_can_message_queues_unit #(
  parameter int APP_RX_DEPTH  = cmq_pkg::DefaultDepth,
  parameter int APP_TX_DEPTH  = cmq_pkg::DefaultDepth,
  parameter int NM_RX_DEPTH   = cmq_pkg::DefaultDepth,
  parameter int NM_TX_DEPTH   = cmq_pkg::DefaultDepth,
  parameter int DIAG_RX_DEPTH = cmq_pkg::DefaultDepth,
  parameter int DIAG_TX_DEPTH = cmq_pkg::DefaultDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // frame_kind, msg_id, payload, length, rx_side, enable_flag,
  // ctrl_type, com_type, no_ack, bus_off
  input  logic [cmq_pkg::InDataW-1:0]  s_axis_tdata,
  // command, channel
  input  logic [cmq_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_frame_kind, out_msg_id, out_length, out_payload
  output logic [cmq_pkg::OutDataW-1:0] m_axis_tdata,
  // ok
  output logic [cmq_pkg::OutUserW-1:0] m_axis_tuser
);

  cmq_pkg::mem_req_t            mem_req;
  logic [cmq_pkg::EntryW-1:0]   mem_rdata;

  cmq_ctrl #(
    .APP_RX_DEPTH  (APP_RX_DEPTH),
    .APP_TX_DEPTH  (APP_TX_DEPTH),
    .NM_RX_DEPTH   (NM_RX_DEPTH),
    .NM_TX_DEPTH   (NM_TX_DEPTH),
    .DIAG_RX_DEPTH (DIAG_RX_DEPTH),
    .DIAG_TX_DEPTH (DIAG_TX_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  cmq_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule
